FILE: rtl/lbh_pkg.sv
// Shared types, register indexes and heartbeat constants of the LED breathing and heartbeat core.
`default_nettype none

package lbh_pkg;

   typedef enum logic [1:0] {
      FADE_IN  = 2'd0,
      FADE_DIM = 2'd1,
      FADE_GAP = 2'd2
   } fade_phase_type;

   localparam logic [2:0] CSR_FADE_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_PULSE_ENABLE   = 3'd1;
   localparam logic [2:0] CSR_PWM_PERIOD_US  = 3'd2;
   localparam logic [2:0] CSR_DUTY_STEP_US   = 3'd3;
   localparam logic [2:0] CSR_FADE_GAP_TICKS = 3'd4;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   localparam logic [11:0] PWM_PERIOD_RESET = 12'd4000;
   localparam logic [7:0]  DUTY_STEP_RESET  = 8'd20;
   localparam logic [11:0] OFF_TIME_RESET   = 12'd3980;
   localparam logic [11:0] OFF_TIME_MAX     = 12'hFFF;
   localparam logic [15:0] GAP_COUNT_MAX    = 16'hFFFF;

   localparam logic [2:0] PULSE_STEPS     = 3'd6;
   localparam logic [2:0] PULSE_LAST_STEP = 3'd5;

   function automatic logic [11:0] pulse_len(input logic [2:0] step);
      logic [11:0] len;
      case (step)
         3'd0:    len = 12'd300;
         3'd1:    len = 12'd700;
         3'd2:    len = 12'd100;
         3'd3:    len = 12'd200;
         3'd4:    len = 12'd100;
         3'd5:    len = 12'd2600;
         default: len = 12'd300;
      endcase
      return len;
   endfunction

   function automatic logic pulse_lit(input logic [2:0] step);
      logic lit;
      case (step)
         3'd0:    lit = 1'b1;
         3'd2:    lit = 1'b1;
         3'd4:    lit = 1'b1;
         default: lit = 1'b0;
      endcase
      return lit;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/led_breathing_and_heartbeat_core.sv
// Top level of the LED breathing fader and heartbeat pulser.
`default_nettype none

// Each request transfer is one microsecond tick, with req_sys_tick set when it is also a
// system tick, and it yields exactly one response transfer carrying both LED drives. The core
// takes one tick per clock: the fade and heartbeat state and the LED values are all registered
// in the accepting cycle, and the response carrying them appears in the next cycle. A held
// response blocks a new request only while rsp_stall is high. Configuration writes never touch
// the channel state; a disabled channel keeps its state and drives its LED off.
module led_breathing_and_heartbeat_core #(
   parameter int unsigned TICKS_PER_SECOND = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_sys_tick,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_fade_led,
   output logic             rsp_pulse_led,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [lbh_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam logic [15:0] FADE_GAP_RESET = 16'(4 * TICKS_PER_SECOND);

   logic        fade_enable_ff;
   logic        pulse_enable_ff;
   logic [11:0] pwm_period_ff;
   logic [7:0]  duty_step_ff;
   logic [15:0] fade_gap_ff;

   lbh_pkg::fade_phase_type fade_phase_ff, fade_phase_in;
   logic [11:0] off_time_ff, off_time_in;
   logic [11:0] pwm_counter_ff, pwm_counter_in;
   logic [15:0] gap_counter_ff, gap_counter_in;
   logic [2:0]  pulse_step_ff, pulse_step_in;
   logic [11:0] pulse_counter_ff, pulse_counter_in;

   logic rsp_valid_ff;
   logic fade_led_ff, fade_led_in;
   logic pulse_led_ff, pulse_led_in;

   logic req_accept;
   logic [11:0] step_ext;
   logic [11:0] per_minus_step;
   logic [11:0] lit_limit;
   logic [12:0] pwm_plus;
   logic [12:0] off_sum;
   logic [2:0]  pulse_step_cur;
   logic [11:0] pulse_count_next;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fade_led  = fade_led_ff;
   assign rsp_pulse_led = pulse_led_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_enable_ff  <= 1'b0;
         pulse_enable_ff <= 1'b0;
         pwm_period_ff   <= lbh_pkg::PWM_PERIOD_RESET;
         duty_step_ff    <= lbh_pkg::DUTY_STEP_RESET;
         fade_gap_ff     <= FADE_GAP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lbh_pkg::CSR_FADE_ENABLE:    fade_enable_ff  <= csr_wdata[0];
            lbh_pkg::CSR_PULSE_ENABLE:   pulse_enable_ff <= csr_wdata[0];
            lbh_pkg::CSR_PWM_PERIOD_US:  pwm_period_ff   <= csr_wdata[11:0];
            lbh_pkg::CSR_DUTY_STEP_US:   duty_step_ff    <= csr_wdata[7:0];
            lbh_pkg::CSR_FADE_GAP_TICKS: fade_gap_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign step_ext       = {4'd0, duty_step_ff};
   assign per_minus_step = (pwm_period_ff > step_ext) ? (pwm_period_ff - step_ext) : 12'd0;

   always_comb begin
      fade_phase_in  = fade_phase_ff;
      off_time_in    = off_time_ff;
      pwm_counter_in = pwm_counter_ff;
      gap_counter_in = gap_counter_ff;
      fade_led_in    = 1'b0;
      lit_limit      = 12'd0;
      pwm_plus       = {1'b0, pwm_counter_ff} + 13'd1;
      off_sum        = 13'd0;
      if (fade_enable_ff) begin
         if (pwm_counter_ff == 12'd0) begin
            if (fade_phase_in == lbh_pkg::FADE_IN && off_time_in <= step_ext) begin
               fade_phase_in = lbh_pkg::FADE_DIM;
               off_time_in   = step_ext;
            end
            if (fade_phase_in == lbh_pkg::FADE_DIM && off_time_in >= per_minus_step) begin
               fade_phase_in  = lbh_pkg::FADE_GAP;
               gap_counter_in = 16'd0;
            end
         end
         case (fade_phase_in)
            lbh_pkg::FADE_IN, lbh_pkg::FADE_DIM: begin
               lit_limit = (pwm_period_ff > off_time_in) ? (pwm_period_ff - off_time_in)
                                                         : 12'd0;
               fade_led_in = (pwm_counter_ff < lit_limit);
               if (pwm_plus >= {1'b0, pwm_period_ff}) begin
                  pwm_counter_in = 12'd0;
                  if (fade_phase_in == lbh_pkg::FADE_IN) begin
                     off_time_in = (off_time_in > step_ext) ? (off_time_in - step_ext) : 12'd0;
                  end else begin
                     off_sum     = {1'b0, off_time_in} + {1'b0, step_ext};
                     off_time_in = off_sum[12] ? lbh_pkg::OFF_TIME_MAX : off_sum[11:0];
                  end
               end else begin
                  pwm_counter_in = pwm_plus[11:0];
               end
            end
            default: begin
               if (req_sys_tick && gap_counter_in != lbh_pkg::GAP_COUNT_MAX) begin
                  gap_counter_in = gap_counter_in + 16'd1;
               end
               if (gap_counter_in >= fade_gap_ff) begin
                  fade_phase_in  = lbh_pkg::FADE_IN;
                  off_time_in    = per_minus_step;
                  pwm_counter_in = 12'd0;
               end
            end
         endcase
      end
   end

   always_comb begin
      pulse_step_cur   = (pulse_step_ff >= lbh_pkg::PULSE_STEPS) ? 3'd0 : pulse_step_ff;
      pulse_step_in    = pulse_step_ff;
      pulse_counter_in = pulse_counter_ff;
      pulse_count_next = pulse_counter_ff + 12'd1;
      pulse_led_in     = 1'b0;
      if (pulse_enable_ff) begin
         pulse_step_in = pulse_step_cur;
         if (req_sys_tick) begin
            if (pulse_count_next >= lbh_pkg::pulse_len(pulse_step_cur)) begin
               pulse_counter_in = 12'd0;
               pulse_step_in    = (pulse_step_cur == lbh_pkg::PULSE_LAST_STEP) ? 3'd0
                                                                              : pulse_step_cur + 3'd1;
            end else begin
               pulse_counter_in = pulse_count_next;
            end
         end
         pulse_led_in = lbh_pkg::pulse_lit(pulse_step_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_phase_ff    <= lbh_pkg::FADE_IN;
         off_time_ff      <= lbh_pkg::OFF_TIME_RESET;
         pwm_counter_ff   <= 12'd0;
         gap_counter_ff   <= 16'd0;
         pulse_step_ff    <= 3'd0;
         pulse_counter_ff <= 12'd0;
      end else if (req_accept) begin
         fade_phase_ff    <= fade_phase_in;
         off_time_ff      <= off_time_in;
         pwm_counter_ff   <= pwm_counter_in;
         gap_counter_ff   <= gap_counter_in;
         pulse_step_ff    <= pulse_step_in;
         pulse_counter_ff <= pulse_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fade_led_ff  <= fade_led_in;
         pulse_led_ff <= pulse_led_in;
      end
   end

`ifndef SYNTHESIS
   a_pulse_step_range: assert property (@(posedge clock) disable iff (reset)
      pulse_step_ff < lbh_pkg::PULSE_STEPS)
      else $error("heartbeat step left its range");

   a_pulse_count_range: assert property (@(posedge clock) disable iff (reset)
      pulse_counter_ff < 12'd2600)
      else $error("heartbeat counter passed the longest interval");

   a_fade_off_dark: assert property (@(posedge clock) disable iff (reset)
      req_accept && !fade_enable_ff |=> !rsp_fade_led)
      else $error("disabled fade channel produced a lit LED");

   a_fade_frozen: assert property (@(posedge clock) disable iff (reset)
      req_accept && !fade_enable_ff |=> $stable(off_time_ff) && $stable(pwm_counter_ff)
                                        && $stable(gap_counter_ff))
      else $error("disabled fade channel changed its state");

   a_pulse_off_dark: assert property (@(posedge clock) disable iff (reset)
      req_accept && !pulse_enable_ff |=> !rsp_pulse_led && $stable(pulse_counter_ff))
      else $error("disabled heartbeat channel was lit or advanced");
`endif

endmodule

`default_nettype wire

FILE: bench/led_breathing_and_heartbeat_core_tb.sv
// Self-checking testbench for the LED breathing fader and heartbeat pulser core.
`timescale 1ns / 100ps

module led_breathing_and_heartbeat_core_tb;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned BEAT_LEN [6] = '{300, 700, 100, 200, 100, 2600};
   localparam logic [5:0]  BEAT_LIT = 6'b010101;

   typedef struct packed {
      logic fade;
      logic pulse;
   } led_pair_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_sys_tick = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_fade_led;
   logic rsp_pulse_led;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = lbh_pkg::CSR_FADE_ENABLE;
   logic [lbh_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   logic        cfg_fade_en = 1'b0;
   logic        cfg_pulse_en = 1'b0;
   logic [11:0] cfg_period = lbh_pkg::PWM_PERIOD_RESET;
   logic [7:0]  cfg_step = lbh_pkg::DUTY_STEP_RESET;
   logic [15:0] cfg_gap = 16'd512;

   lbh_pkg::fade_phase_type fade_state = lbh_pkg::FADE_IN;
   logic [11:0] dark_time = lbh_pkg::OFF_TIME_RESET;
   logic [11:0] pwm_count = '0;
   logic [15:0] gap_count = '0;
   logic [2:0]  beat_step = '0;
   logic [11:0] beat_count = '0;

   logic         tick_queue [$];
   led_pair_type led_queue [$];
   int idle_pct = 0;
   int send_gap = 0;
   int stall_left = 0;
   int mismatch_count = 0;
   int unsigned cycle_count = 0;

   led_breathing_and_heartbeat_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sys_tick  (req_sys_tick),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_fade_led  (rsp_fade_led),
      .rsp_pulse_led (rsp_pulse_led),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_sub(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   function automatic led_pair_type advance_leds(input logic tick);
      led_pair_type leds;
      int unsigned per;
      int unsigned stp;
      leds = '0;
      per = cfg_period;
      stp = cfg_step;
      if (cfg_fade_en) begin
         if (pwm_count == 0) begin
            if (fade_state == lbh_pkg::FADE_IN && dark_time <= stp) begin
               fade_state = lbh_pkg::FADE_DIM;
               dark_time = 12'(stp);
            end
            if (fade_state == lbh_pkg::FADE_DIM && dark_time >= clamp_sub(per, stp)) begin
               fade_state = lbh_pkg::FADE_GAP;
               gap_count = '0;
            end
         end
         if (fade_state != lbh_pkg::FADE_IN && fade_state != lbh_pkg::FADE_DIM) begin
            if (tick && gap_count != lbh_pkg::GAP_COUNT_MAX)
               gap_count++;
            if (gap_count >= cfg_gap) begin
               fade_state = lbh_pkg::FADE_IN;
               dark_time = 12'(clamp_sub(per, stp));
               pwm_count = '0;
            end
         end else begin
            leds.fade = (pwm_count < clamp_sub(per, dark_time));
            if (pwm_count + 1 >= per) begin
               pwm_count = '0;
               if (fade_state == lbh_pkg::FADE_IN)
                  dark_time = 12'(clamp_sub(dark_time, stp));
               else if (dark_time + stp > lbh_pkg::OFF_TIME_MAX)
                  dark_time = lbh_pkg::OFF_TIME_MAX;
               else
                  dark_time = 12'(dark_time + stp);
            end else begin
               pwm_count++;
            end
         end
      end
      if (cfg_pulse_en) begin
         if (tick) begin
            beat_count++;
            if (beat_count >= BEAT_LEN[beat_step]) begin
               beat_count = '0;
               beat_step = (beat_step == lbh_pkg::PULSE_LAST_STEP) ? 3'd0 : beat_step + 3'd1;
            end
         end
         leds.pulse = BEAT_LIT[beat_step];
      end
      return leds;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic write_csr(input logic [2:0] idx,
                            input logic [lbh_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         lbh_pkg::CSR_FADE_ENABLE:    cfg_fade_en = data[0];
         lbh_pkg::CSR_PULSE_ENABLE:   cfg_pulse_en = data[0];
         lbh_pkg::CSR_PWM_PERIOD_US:  cfg_period = data[11:0];
         lbh_pkg::CSR_DUTY_STEP_US:   cfg_step = data[7:0];
         lbh_pkg::CSR_FADE_GAP_TICKS: cfg_gap = data;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (tick_queue.size() != 0 || req_valid || led_queue.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(input logic fe, input logic pe, input logic [11:0] per,
                            input logic [7:0] stp, input logic [15:0] gap, input int pct);
      wait_idle();
      write_csr(lbh_pkg::CSR_FADE_ENABLE, {15'd0, fe});
      write_csr(lbh_pkg::CSR_PULSE_ENABLE, {15'd0, pe});
      write_csr(lbh_pkg::CSR_PWM_PERIOD_US, {4'd0, per});
      write_csr(lbh_pkg::CSR_DUTY_STEP_US, {8'd0, stp});
      write_csr(lbh_pkg::CSR_FADE_GAP_TICKS, gap);
      idle_pct = pct;
   endtask

   task automatic queue_ticks(input int n, input int tick_pct);
      repeat (n) tick_queue.push_back($urandom_range(0, 99) < tick_pct);
   endtask

   always @(posedge clock) begin : drive_ticks
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            led_queue.push_back(advance_leds(req_sys_tick));
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            if (send_gap != 0) begin
               send_gap--;
            end else if (tick_queue.size() != 0) begin
               if ($urandom_range(0, 99) < idle_pct) begin
                  send_gap = $urandom_range(0, 9);
               end else begin
                  req_sys_tick <= tick_queue.pop_front();
                  next_valid = 1'b1;
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   always @(posedge clock) begin : check_leds
      led_pair_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (led_queue.size() == 0) begin
               report_mismatch("response transfer with no tick outstanding");
            end else begin
               want = led_queue.pop_front();
               if (rsp_fade_led !== want.fade)
                  report_mismatch($sformatf("fade_led got %b, expected %b",
                                            rsp_fade_led, want.fade));
               if (rsp_pulse_led !== want.pulse)
                  report_mismatch($sformatf("pulse_led got %b, expected %b",
                                            rsp_pulse_led, want.pulse));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [2:0] idx;
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Both channels are disabled after reset, so both LEDs stay dark.
      idle_pct = 10;
      queue_ticks(4, 50);

      // A zero period ends every PWM period at once; with the largest step and no gap
      // the fade runs through fade-in, fade-out and the gap within the queued transfers.
      configure(1'b1, 1'b1, 12'd0, 8'd255, 16'd0, 10);
      idx = lbh_pkg::CSR_FADE_GAP_TICKS;
      repeat (3) begin
         idx++;
         write_csr(idx, 16'($urandom));
      end
      write_csr(idx, '1);
      queue_ticks(18, 50);

      configure(1'b1, 1'b1, 12'd100, 8'd45, 16'd3, 20);
      queue_ticks(350, 85);
      configure(1'b1, 1'b1, 12'd4095, 8'd255, 16'hFFFF, 0);
      queue_ticks(150, 85);
      configure(1'b1, 1'b0, 12'd130, 8'd1, 16'd1, 10);
      queue_ticks(150, 60);
      configure(1'b0, 1'b1, 12'd100, 8'd30, 16'd0, 20);
      queue_ticks(100, 90);
      for (k = 0; k < 4; k++) begin
         configure(1'b1, 1'b1, 12'($urandom_range(100, 180)), 8'($urandom_range(20, 70)),
                   16'($urandom_range(0, 6)), $urandom_range(0, 1) ? 15 : 0);
         queue_ticks(150, 85);
      end
      configure(1'b1, 1'b1, 12'd120, 8'd25, 16'd5, 0);
      queue_ticks(380, 85);

      for (k = 0; k < 10000 && (tick_queue.size() != 0 || req_valid || led_queue.size() != 0);
           k++)
         @(posedge clock);
      repeat (5) @(posedge clock);
      if (tick_queue.size() != 0 || led_queue.size() != 0)
         report_mismatch($sformatf("%0d ticks unsent and %0d responses missing",
                                   tick_queue.size(), led_queue.size()));
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
